FILE: design/ncc_pkg.sv
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared field widths, center entry layout and sequencer states for the
// nearest center classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

  localparam int RA_W      = 25;
  localparam int DEC_W     = 24;
  localparam int ENTRY_W   = 9;
  localparam int PC_W      = 10;
  localparam int ROW_W     = 32;
  localparam int DIST_W    = 2 * RA_W + 1;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 96;

  // cycles from the last table read issue to the final best update
  localparam int DRAIN_CYCLES = 3;

  localparam logic [PC_W-1:0] PC_RESET = 10'd512;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  typedef logic [RA_W-1:0]          ra_t;
  typedef logic signed [DEC_W-1:0]  dec_t;
  typedef logic [DIST_W-1:0]        dist_t;

  typedef struct packed {
    dec_t dec;
    ra_t  ra;
  } center_t;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_CNT_RD = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

endpackage

FILE: design/ncc_ram.sv
// ----------------------------------------------------------------------------
// ncc_ram
// Generic simple dual port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ncc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/ncc_dist_unit.sv
// ----------------------------------------------------------------------------
// ncc_dist_unit
// Pipelined squared distance unit: absolute differences, then squares, then
// the sum on the output. One center per cycle, two register stages.
// ----------------------------------------------------------------------------
module ncc_dist_unit #(
  parameter int IDX_W = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [IDX_W-1:0]   in_idx,
  input  ncc_pkg::center_t   point,
  input  ncc_pkg::center_t   center,
  output logic               out_valid,
  output logic [IDX_W-1:0]   out_idx,
  output ncc_pkg::dist_t     out_dist
);

  localparam int RA_W   = ncc_pkg::RA_W;
  localparam int DEC_W  = ncc_pkg::DEC_W;
  localparam int DIST_W = ncc_pkg::DIST_W;

  logic signed [RA_W:0]  ra_diff;
  logic signed [DEC_W:0] dec_diff;
  logic [RA_W-1:0]       ra_abs_next;
  logic [DEC_W-1:0]      dec_abs_next;

  logic                  a_valid;
  logic [IDX_W-1:0]      a_idx;
  logic [RA_W-1:0]       a_ra;
  logic [DEC_W-1:0]      a_dec;

  logic [2*RA_W-1:0]     ra_sq;
  logic [2*DEC_W-1:0]    dec_sq;

  assign ra_diff  = $signed({1'b0, point.ra}) - $signed({1'b0, center.ra});
  assign dec_diff = $signed({point.dec[DEC_W-1], point.dec})
                  - $signed({center.dec[DEC_W-1], center.dec});

  assign ra_abs_next  = ra_diff[RA_W]   ? RA_W'(-ra_diff)   : RA_W'(ra_diff);
  assign dec_abs_next = dec_diff[DEC_W] ? DEC_W'(-dec_diff) : DEC_W'(dec_diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_idx   <= in_idx;
    a_ra    <= ra_abs_next;
    a_dec   <= dec_abs_next;
    out_idx <= a_idx;
    ra_sq   <= a_ra * a_ra;
    dec_sq  <= a_dec * a_dec;
  end

  assign out_dist = DIST_W'(ra_sq) + DIST_W'(dec_sq);

endmodule

FILE: design/nearest_center_classifier_unit.sv
// ----------------------------------------------------------------------------
// nearest_center_classifier_unit
// Nearest patch center search with per-patch hit counters.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser is the mode (0 load a center, 1 classify a point).
// A load writes one center and returns an all-zero result.
// A classify streams the first n centers (n is patch_count, zero taken as
// one, capped at MAX_PATCHES) through one pipelined squared distance unit,
// one center per cycle, then reads, bumps and writes back the winner's
// counter.
// The next request is taken the cycle after the result moves into the output
// register.
// Output stream m_*: one result per request; a stalled receiver holds the
// result in the output register, and one more request may be taken while
// it waits. patch_count is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle; the block does not enforce it. After reset
// the counter memory is cleared with s_tready low; the center table is not.
// ----------------------------------------------------------------------------
module nearest_center_classifier_unit #(
  parameter int MAX_PATCHES = 512,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,   // patch_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,       // entry_index[8:0], coord_ra[33:9], coord_dec[57:34]
  input  logic        s_tuser,       // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata        // nearest_index[8:0], row_count[40:9],
                                     // first_hit[41], min_distance_sq[92:42]
);

  localparam int RA_W    = ncc_pkg::RA_W;
  localparam int DEC_W   = ncc_pkg::DEC_W;
  localparam int ENTRY_W = ncc_pkg::ENTRY_W;
  localparam int PC_W    = ncc_pkg::PC_W;
  localparam int ROW_W   = ncc_pkg::ROW_W;
  localparam int DIST_W  = ncc_pkg::DIST_W;
  localparam int OUT_W   = ncc_pkg::OUT_DATA_W;
  localparam int IDX_W   = $clog2(MAX_PATCHES);
  localparam int CNT_W   = $clog2(MAX_PATCHES + 1);
  localparam int PCC_W   = (PC_W > CNT_W) ? PC_W : CNT_W;
  localparam int SLC_W   = (ENTRY_W > CNT_W) ? ENTRY_W : CNT_W;
  localparam int CTR_W   = COUNT_WIDTH + 1;
  localparam int DRN_W   = $clog2(ncc_pkg::DRAIN_CYCLES);
  localparam int PAD_W   = OUT_W - (ENTRY_W + ROW_W + 1 + DIST_W);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PATCHES - 1);
  localparam logic [DRN_W-1:0] DRN_LAST = DRN_W'(ncc_pkg::DRAIN_CYCLES - 1);

  ncc_pkg::state_t     state;

  logic [PC_W-1:0]     patch_count;

  // request fields
  logic                in_mode;
  logic [ENTRY_W-1:0]  in_entry;
  ncc_pkg::center_t    in_coord;
  logic                accept;

  // search
  ncc_pkg::center_t    point;
  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W-1:0]    last_idx_next;
  logic [PCC_W-1:0]    pc_ext;
  logic [IDX_W-1:0]    scan_addr;
  logic                p1_valid;
  logic [IDX_W-1:0]    p1_idx;
  logic [DRN_W-1:0]    drain_cnt;
  logic [IDX_W-1:0]    clr_addr;

  ncc_pkg::center_t    ctab_rdata;
  logic                ctab_we;

  logic                d_valid;
  logic [IDX_W-1:0]    d_idx;
  ncc_pkg::dist_t      d_dist;

  logic [IDX_W-1:0]    best_idx;
  ncc_pkg::dist_t      best_dist;

  // counter memory: {occupied mark, count}
  logic                ctr_we;
  logic [IDX_W-1:0]    ctr_waddr;
  logic [CTR_W-1:0]    ctr_wdata;
  logic [CTR_W-1:0]    ctr_rdata;
  logic [COUNT_WIDTH-1:0] cnt_old;
  logic [COUNT_WIDTH-1:0] cnt_new;

  // result
  logic [ENTRY_W-1:0]  res_idx;
  logic [ROW_W-1:0]    res_cnt;
  logic                res_first;
  ncc_pkg::dist_t      res_dist;
  logic                out_load;

  assign in_mode        = s_tuser;
  assign in_entry       = s_tdata[ENTRY_W-1:0];
  assign in_coord.ra    = s_tdata[ENTRY_W +: RA_W];
  assign in_coord.dec   = s_tdata[ENTRY_W+RA_W +: DEC_W];

  assign s_tready = (state == ncc_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // result moves into the output register when that register is free
  assign out_load = (state == ncc_pkg::ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      patch_count <= ncc_pkg::PC_RESET;
    end else if (cfg_wr_en) begin
      patch_count <= cfg_wr_data;
    end
  end

  // zero acts as one, anything above the table size saturates
  always_comb begin
    pc_ext = PCC_W'(patch_count);
    if (pc_ext == '0) begin
      last_idx_next = '0;
    end else if (pc_ext > PCC_W'(MAX_PATCHES)) begin
      last_idx_next = IDX_LAST;
    end else begin
      last_idx_next = IDX_W'(pc_ext - PCC_W'(1));
    end
  end

  assign ctab_we = accept && (in_mode == ncc_pkg::MODE_LOAD)
                && (SLC_W'(in_entry) < SLC_W'(MAX_PATCHES));

  ncc_ram #(
    .WIDTH ($bits(ncc_pkg::center_t)),
    .DEPTH (MAX_PATCHES)
  ) u_center_ram (
    .clk     (clk),
    .wr_en   (ctab_we),
    .wr_addr (IDX_W'(in_entry)),
    .wr_data (in_coord),
    .rd_addr (scan_addr),
    .rd_data (ctab_rdata)
  );

  ncc_dist_unit #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p1_valid),
    .in_idx    (p1_idx),
    .point     (point),
    .center    (ctab_rdata),
    .out_valid (d_valid),
    .out_idx   (d_idx),
    .out_dist  (d_dist)
  );

  assign cnt_old = ctr_rdata[COUNT_WIDTH-1:0];
  assign cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + COUNT_WIDTH'(1);

  always_comb begin
    if (state == ncc_pkg::ST_CLEAR) begin
      ctr_we    = 1'b1;
      ctr_waddr = clr_addr;
      ctr_wdata = '0;
    end else begin
      ctr_we    = (state == ncc_pkg::ST_UPDATE);
      ctr_waddr = best_idx;
      ctr_wdata = {1'b1, cnt_new};
    end
  end

  ncc_ram #(
    .WIDTH (CTR_W),
    .DEPTH (MAX_PATCHES)
  ) u_counter_ram (
    .clk     (clk),
    .wr_en   (ctr_we),
    .wr_addr (ctr_waddr),
    .wr_data (ctr_wdata),
    .rd_addr (best_idx),
    .rd_data (ctr_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ncc_pkg::ST_CLEAR;
      clr_addr  <= '0;
      p1_valid  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      p1_valid <= (state == ncc_pkg::ST_SCAN);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ncc_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_LAST) begin
            state <= ncc_pkg::ST_IDLE;
          end
        end
        ncc_pkg::ST_IDLE: begin
          if (accept) begin
            if (in_mode == ncc_pkg::MODE_CLASSIFY) begin
              state <= ncc_pkg::ST_SCAN;
            end else begin
              state <= ncc_pkg::ST_DONE;
            end
          end
        end
        ncc_pkg::ST_SCAN: begin
          if (scan_addr == last_idx) begin
            state <= ncc_pkg::ST_DRAIN;
          end
        end
        ncc_pkg::ST_DRAIN: begin
          if (drain_cnt == DRN_LAST) begin
            state <= ncc_pkg::ST_CNT_RD;
          end
        end
        ncc_pkg::ST_CNT_RD: begin
          state <= ncc_pkg::ST_UPDATE;
        end
        ncc_pkg::ST_UPDATE: begin
          state <= ncc_pkg::ST_DONE;
        end
        ncc_pkg::ST_DONE: begin
          if (out_load) begin
            state <= ncc_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ncc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p1_idx <= scan_addr;
    if (accept) begin
      point     <= in_coord;
      last_idx  <= last_idx_next;
      scan_addr <= '0;
      drain_cnt <= '0;
      res_idx   <= '0;
      res_cnt   <= '0;
      res_first <= 1'b0;
      res_dist  <= '0;
    end
    if (state == ncc_pkg::ST_SCAN && scan_addr != last_idx) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end
    if (state == ncc_pkg::ST_DRAIN) begin
      drain_cnt <= drain_cnt + DRN_W'(1);
    end
    // first center seeds the search; later ones must be strictly closer
    if (d_valid && (d_idx == '0 || d_dist < best_dist)) begin
      best_idx  <= d_idx;
      best_dist <= d_dist;
    end
    if (state == ncc_pkg::ST_UPDATE) begin
      res_idx   <= ENTRY_W'(best_idx);
      res_cnt   <= ROW_W'(cnt_new);
      res_first <= ~ctr_rdata[COUNT_WIDTH];
      res_dist  <= best_dist;
    end
    if (out_load) begin
      m_tdata <= {PAD_W'(0), res_dist, res_first, res_cnt, res_idx};
    end
  end

endmodule
